// ===== design/cfr_pkg.sv =====
`timescale 1ns / 1ps
package cfr_pkg;
  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int ID_BYTES = 1;
  localparam int LEN_BYTES = 2;
  localparam int TYPE_BYTES = 1;
  localparam int LEN_W = LEN_BYTES * 8;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_XOR8 = 2'd1;
  localparam logic [1:0] MODE_CRC16 = 2'd2;
  localparam logic [1:0] MODE_CRC32 = 2'd3;

  localparam logic [1:0] REG_CHECK_MODE = 2'd0;
  localparam logic [1:0] REG_USE_START = 2'd1;
  localparam logic [1:0] REG_START_VAL = 2'd2;
  localparam logic [1:0] REG_IDLE_LIMIT = 2'd3;

  localparam logic [15:0] POLY16_REFL = 16'hA001;
  localparam logic [31:0] POLY32_REFL = 32'hEDB88320;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_ident;
    logic [7:0] frame_kind;
    logic [5:0] frame_length;
    logic [7:0] payload_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  check_mode;
    logic        use_start_byte;
    logic [7:0]  start_byte_value;
    logic [15:0] idle_limit;
  } cfg_regs_t;

  // Request from the parser to read out a verified frame.
  typedef struct packed {
    logic             go;
    logic [7:0]       ident;
    logic [7:0]       kind;
    logic [LEN_W-1:0] length;
  } emit_req_t;

  function automatic logic [2:0] check_bytes(input logic [1:0] mode);
    unique case (mode)
      MODE_NONE:  check_bytes = 3'd0;
      MODE_XOR8:  check_bytes = 3'd1;
      MODE_CRC16: check_bytes = 3'd2;
      default:    check_bytes = 3'd4;
    endcase
  endfunction

  function automatic logic [31:0] check_mask(input logic [1:0] mode);
    unique case (mode)
      MODE_NONE:  check_mask = 32'h0;
      MODE_XOR8:  check_mask = 32'hFF;
      MODE_CRC16: check_mask = 32'hFFFF;
      default:    check_mask = 32'hFFFFFFFF;
    endcase
  endfunction

  function automatic logic [31:0] check_init(input logic [1:0] mode);
    check_init = (mode == MODE_CRC32) ? 32'hFFFFFFFF : 32'h0;
  endfunction

  // One byte into the running check; the CRC modes take eight bit steps on a 32-bit value.
  function automatic logic [31:0] check_add(input logic [1:0] mode,
                                            input logic [31:0] c_in,
                                            input logic [7:0] b);
    logic [31:0] c;
    c = c_in;
    unique case (mode)
      MODE_XOR8: check_add = {24'h0, c[7:0] ^ b};
      MODE_CRC16: begin
        c = {16'h0, c[15:0] ^ {8'h0, b}};
        for (int i = 0; i < 8; i++) begin
          c = c[0] ? ((c >> 1) ^ {16'h0, POLY16_REFL}) : (c >> 1);
        end
        check_add = c;
      end
      MODE_CRC32: begin
        c = c ^ {24'h0, b};
        for (int i = 0; i < 8; i++) begin
          c = c[0] ? ((c >> 1) ^ POLY32_REFL) : (c >> 1);
        end
        check_add = c;
      end
      default: check_add = 32'h0;
    endcase
  endfunction

  function automatic logic [31:0] check_final(input logic [1:0] mode,
                                              input logic [31:0] c);
    unique case (mode)
      MODE_XOR8:  check_final = {24'h0, ~c[7:0]};
      MODE_CRC16: check_final = {16'h0, c[15:0]};
      MODE_CRC32: check_final = ~c;
      default:    check_final = 32'h0;
    endcase
  endfunction
endpackage

// ===== design/cfr_parser.sv =====
`timescale 1ns / 1ps
module cfr_parser #(
  parameter int MAX_PAYLOAD = cfr_pkg::MAX_PAYLOAD_DEF,
  parameter int AW = $clog2(MAX_PAYLOAD)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  cfr_pkg::in_item_t    item,
  input  cfr_pkg::cfg_regs_t   cfg,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [7:0]           wr_data,
  output cfr_pkg::emit_req_t   req
);
  localparam int LW = cfr_pkg::LEN_W;
  localparam bit ID_DONE_FIRST = (cfr_pkg::ID_BYTES <= 1);

  typedef enum logic [6:0] {
    PH_START  = 7'b0000001,
    PH_IDENT  = 7'b0000010,
    PH_LEN    = 7'b0000100,
    PH_KIND   = 7'b0001000,
    PH_HCHECK = 7'b0010000,
    PH_DATA   = 7'b0100000,
    PH_DCHECK = 7'b1000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic [7:0]  held_ident, held_ident_next, held_kind, held_kind_next;
  logic [LW-1:0] held_length, held_length_next;
  logic [31:0] running_check, running_check_next, received_check, received_check_next;
  logic        discard_flag, discard_flag_next;
  logic [15:0] idle_ticks, idle_ticks_next;

  logic [7:0]  c;
  logic [2:0]  nchk;
  logic [31:0] rc_shift;
  logic        chk_ok;
  phase_t      ph;
  logic [15:0] cnt1;
  logic        len_over;

  assign c = item.byte_in;
  assign nchk = cfr_pkg::check_bytes(cfg.check_mode);
  assign rc_shift = {received_check[23:0], c};
  assign chk_ok = ((cfr_pkg::check_final(cfg.check_mode, running_check)
                    ^ rc_shift) & cfr_pkg::check_mask(cfg.check_mode)) == 32'h0;
  assign len_over = {{(32-LW){1'b0}}, held_length} > 32'(MAX_PAYLOAD);
  assign cnt1 = byte_count + 16'd1;

  always_comb begin
    phase_next = phase;
    byte_count_next = byte_count;
    held_ident_next = held_ident;
    held_kind_next = held_kind;
    held_length_next = held_length;
    running_check_next = running_check;
    received_check_next = received_check;
    discard_flag_next = discard_flag;
    idle_ticks_next = idle_ticks;
    wr_en = 1'b0;
    wr_addr = byte_count[AW-1:0];
    wr_data = c;
    req.go = 1'b0;
    req.ident = held_ident;
    req.kind = held_kind;
    req.length = held_length;
    ph = phase;
    if (take) begin
      if (item.command) begin
        if (idle_ticks < cfg.idle_limit) idle_ticks_next = idle_ticks + 16'd1;
      end else begin
        if (idle_ticks >= cfg.idle_limit) ph = PH_START;
        idle_ticks_next = 16'd0;
        // Leaving the start phase: either a matching start byte or none used.
        if (ph == PH_START && (!cfg.use_start_byte || c == cfg.start_byte_value)) begin
          running_check_next = cfr_pkg::check_init(cfg.check_mode);
          if (cfg.use_start_byte) begin
            running_check_next = cfr_pkg::check_add(cfg.check_mode,
                                   running_check_next, cfg.start_byte_value);
          end
          discard_flag_next = 1'b0;
          byte_count_next = 16'd0;
          phase_next = PH_IDENT;
          if (!cfg.use_start_byte) begin
            // The byte itself is the first ID byte.
            running_check_next = cfr_pkg::check_add(cfg.check_mode,
                                   running_check_next, c);
            held_ident_next = c;
            if (ID_DONE_FIRST) phase_next = PH_LEN;
            else byte_count_next = 16'd1;
          end
        end else begin
          unique case (ph)
            PH_START: phase_next = PH_START;
            PH_IDENT: begin
              running_check_next = cfr_pkg::check_add(cfg.check_mode, running_check, c);
              held_ident_next = c;
              byte_count_next = cnt1;
              phase_next = PH_IDENT;
              if (cnt1 >= 16'(cfr_pkg::ID_BYTES)) begin
                phase_next = PH_LEN;
                byte_count_next = 16'd0;
              end
            end
            PH_LEN: begin
              running_check_next = cfr_pkg::check_add(cfg.check_mode, running_check, c);
              held_length_next = LW'({held_length, c});
              byte_count_next = cnt1;
              phase_next = PH_LEN;
              if (cnt1 >= 16'(cfr_pkg::LEN_BYTES)) begin
                phase_next = PH_KIND;
                byte_count_next = 16'd0;
              end
            end
            PH_KIND: begin
              running_check_next = cfr_pkg::check_add(cfg.check_mode, running_check, c);
              held_kind_next = c;
              byte_count_next = cnt1;
              phase_next = PH_KIND;
              if (cnt1 >= 16'(cfr_pkg::TYPE_BYTES)) begin
                byte_count_next = 16'd0;
                if (nchk != 3'd0) begin
                  phase_next = PH_HCHECK;
                  received_check_next = 32'h0;
                end else if (held_length == '0) begin
                  phase_next = PH_START;
                  req.go = 1'b1;
                end else begin
                  phase_next = PH_DATA;
                  running_check_next = cfr_pkg::check_init(cfg.check_mode);
                  discard_flag_next = len_over;
                end
              end
            end
            PH_HCHECK: begin
              received_check_next = rc_shift;
              byte_count_next = cnt1;
              phase_next = PH_HCHECK;
              if (cnt1 >= {13'd0, nchk}) begin
                byte_count_next = 16'd0;
                if (!chk_ok) phase_next = PH_START;
                else if (held_length == '0) begin
                  phase_next = PH_START;
                  req.go = 1'b1;
                end else begin
                  phase_next = PH_DATA;
                  running_check_next = cfr_pkg::check_init(cfg.check_mode);
                  discard_flag_next = len_over;
                end
              end
            end
            PH_DATA: begin
              if (!discard_flag) begin
                running_check_next = cfr_pkg::check_add(cfg.check_mode, running_check, c);
                wr_en = byte_count < 16'(MAX_PAYLOAD);
              end
              byte_count_next = cnt1;
              phase_next = PH_DATA;
              if ({{(32-16){1'b0}}, cnt1} >= {{(32-LW){1'b0}}, held_length}) begin
                byte_count_next = 16'd0;
                if (nchk != 3'd0) begin
                  phase_next = PH_DCHECK;
                  received_check_next = 32'h0;
                end else begin
                  phase_next = PH_START;
                  req.go = !discard_flag;
                end
              end
            end
            PH_DCHECK: begin
              received_check_next = rc_shift;
              byte_count_next = cnt1;
              phase_next = PH_DCHECK;
              if (cnt1 >= {13'd0, nchk}) begin
                byte_count_next = 16'd0;
                phase_next = PH_START;
                req.go = !discard_flag && chk_ok;
              end
            end
            default: phase_next = PH_START;
          endcase
        end
      end
    end
    req.ident = held_ident_next;
    req.kind = held_kind_next;
    req.length = held_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      byte_count <= '0;
      held_ident <= '0;
      held_kind <= '0;
      held_length <= '0;
      running_check <= '0;
      received_check <= '0;
      discard_flag <= 1'b0;
      idle_ticks <= '0;
    end else begin
      phase <= phase_next;
      byte_count <= byte_count_next;
      held_ident <= held_ident_next;
      held_kind <= held_kind_next;
      held_length <= held_length_next;
      running_check <= running_check_next;
      received_check <= received_check_next;
      discard_flag <= discard_flag_next;
      idle_ticks <= idle_ticks_next;
    end
  end

  a_idle_sat: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $past(cfg.idle_limit) == cfg.idle_limit
    && $past(idle_ticks) <= cfg.idle_limit |-> idle_ticks <= cfg.idle_limit)
    else $error("idle counter passed its limit");
  a_wr_data: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> phase == PH_DATA && !discard_flag)
    else $error("payload write outside data phase");
  a_go_byte: assert property (@(posedge clk) disable iff (rst)
    req.go |-> take && !item.command)
    else $error("frame emitted without a byte");
endmodule

// ===== design/cfr_readout.sv =====
`timescale 1ns / 1ps
module cfr_readout #(
  parameter int MAX_PAYLOAD = cfr_pkg::MAX_PAYLOAD_DEF,
  parameter int AW = $clog2(MAX_PAYLOAD)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [7:0]          wr_data,
  input  cfr_pkg::emit_req_t  req,
  output logic                busy,
  output logic                out_valid,
  output cfr_pkg::out_item_t  out_item,
  input  logic                out_stall
);
  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam int LW = cfr_pkg::LEN_W;

  logic [7:0] mem [MAX_PAYLOAD];
  logic [7:0] rd_data;
  logic [AW-1:0] rd_addr;

  logic          active;          // reading the stored payload
  logic          rd_pend;         // a read issued last cycle
  logic [CW-1:0] issue_cnt, total;
  logic          pend_last;
  logic [7:0]    h_ident, h_kind;
  logic [5:0]    h_len;
  logic          slot_free;

  assign slot_free = !out_valid || !out_stall;
  // One read in flight at most; issue only when the output slot will be free.
  logic issue;
  assign issue = active && !rd_pend && slot_free;
  assign rd_addr = issue_cnt[AW-1:0];
  assign busy = active || rd_pend || out_valid;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (issue) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      rd_pend <= 1'b0;
      out_valid <= 1'b0;
      issue_cnt <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      rd_pend <= issue;
      if (rd_pend) begin
        out_valid <= 1'b1;
        out_item.frame_ident <= h_ident;
        out_item.frame_kind <= h_kind;
        out_item.frame_length <= h_len;
        out_item.payload_byte <= rd_data;
        out_item.last <= pend_last;
      end
      if (issue) begin
        issue_cnt <= issue_cnt + CW'(1);
        pend_last <= (issue_cnt + CW'(1)) == total;
        if ((issue_cnt + CW'(1)) == total) active <= 1'b0;
      end
      if (req.go) begin
        h_ident <= req.ident;
        h_kind <= req.kind;
        h_len <= req.length[5:0];
        issue_cnt <= '0;
        if (req.length == '0) begin
          out_valid <= 1'b1;
          out_item.frame_ident <= req.ident;
          out_item.frame_kind <= req.kind;
          out_item.frame_length <= '0;
          out_item.payload_byte <= '0;
          out_item.last <= 1'b1;
        end else begin
          active <= 1'b1;
          total <= ({{(32-LW){1'b0}}, req.length} > 32'(MAX_PAYLOAD))
                   ? CW'(MAX_PAYLOAD) : CW'(req.length);
        end
      end
    end
  end

  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    req.go |-> !active && !rd_pend)
    else $error("frame request while reading out");
  a_pend_slot: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !out_valid)
    else $error("read data arrived with output slot full");
  a_last_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.last && !out_stall |-> !active)
    else $error("readout continues past last item");
endmodule

// ===== design/checked_frame_receiver.sv =====
`timescale 1ns / 1ps
// Serial frame receiver. Each input item is a received byte or a timer tick;
// bytes are parsed as optional start byte, ID, big-endian length, type, a
// header check, the payload and a payload check (none, inverted XOR-8,
// CRC-16/ARC or CRC-32). The parser takes a new item whenever the block is not
// busy. A verified frame is stored in a small payload memory during the data
// phase and then read out one result item per payload byte (or a single item
// for an empty frame); during readout the input is stalled, and the results
// come out one at a time because the memory read is registered and only one
// read is kept in flight. Configuration registers: 0 check mode, 1 use
// start byte, 2 start byte value, 3 idle limit; write them only while the
// block is idle.
module checked_frame_receiver #(
  parameter int MAX_PAYLOAD = cfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  cfr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output cfr_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  cfr_pkg::cfg_regs_t  cfg;
  cfr_pkg::emit_req_t  req;
  logic                busy, take, wr_en;
  logic [AW-1:0]       wr_addr;
  logic [7:0]          wr_data;

  // The parser waits while a verified frame is being read out.
  assign in_stall = busy;
  assign take = in_valid && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_mode <= cfr_pkg::MODE_CRC16;
      cfg.use_start_byte <= 1'b1;
      cfg.start_byte_value <= 8'd1;
      cfg.idle_limit <= 16'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cfr_pkg::REG_CHECK_MODE: cfg.check_mode <= cfg_data[1:0];
        cfr_pkg::REG_USE_START:  cfg.use_start_byte <= cfg_data[0];
        cfr_pkg::REG_START_VAL:  cfg.start_byte_value <= cfg_data[7:0];
        default:                 cfg.idle_limit <= cfg_data[15:0];
      endcase
    end
  end

  cfr_parser #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW)) u_parser (
    .clk, .rst, .take, .item(in_item), .cfg,
    .wr_en, .wr_addr, .wr_data, .req
  );

  cfr_readout #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW)) u_readout (
    .clk, .rst, .wr_en, .wr_addr, .wr_data, .req, .busy,
    .out_valid, .out_item, .out_stall
  );

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    req.go |=> in_stall)
    else $error("input not held after a frame was verified");
endmodule

// ===== verif/checked_frame_receiver_tb.sv =====
`timescale 1ns / 1ps
module checked_frame_receiver_tb;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  cfr_pkg::in_item_t  in_item;
  logic       out_valid;
  logic       out_stall;
  cfr_pkg::out_item_t out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  checked_frame_receiver dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Parser phases of the predictor.
  typedef enum logic [2:0] {
    P_START, P_IDENT, P_LEN, P_KIND, P_HCHECK, P_DATA, P_DCHECK
  } phase_t;

  // Predictor copy of the configuration registers.
  logic [1:0]  mode_m;
  logic        start_en_m;
  logic [7:0]  start_val_m;
  logic [15:0] idle_lim_m;

  // Predictor copy of the parser state.
  phase_t      ph;
  logic [15:0] cnt;
  logic [7:0]  f_ident;
  logic [15:0] f_len;
  logic [7:0]  f_kind;
  logic [31:0] run_chk;
  logic [31:0] rx_chk;
  logic        drop_frame;
  logic [7:0]  pay_mem [0:31];
  logic [15:0] ticks;

  cfr_pkg::out_item_t pending_frames [$];
  int          errors;
  bit          sender_idle_en;
  bit          recv_idle_en;
  bit          long_hold_req;
  bit          long_hold_done;
  int          hold_cycles;

  initial begin
    clk = 1'b0;
  end
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The predictor has its own check arithmetic.
  function automatic logic [2:0] chk_len(input logic [1:0] m);
    case (m)
      cfr_pkg::MODE_NONE:  chk_len = 3'd0;
      cfr_pkg::MODE_XOR8:  chk_len = 3'd1;
      cfr_pkg::MODE_CRC16: chk_len = 3'd2;
      default:             chk_len = 3'd4;
    endcase
  endfunction

  function automatic logic [31:0] chk_seed(input logic [1:0] m);
    chk_seed = (m == cfr_pkg::MODE_CRC32) ? 32'hFFFF_FFFF : 32'h0;
  endfunction

  function automatic logic [31:0] chk_update(input logic [1:0] m, input logic [31:0] c,
                                             input logic [7:0] b);
    logic [31:0] r;
    r = c;
    case (m)
      cfr_pkg::MODE_XOR8: chk_update = {24'h0, r[7:0] ^ b};
      cfr_pkg::MODE_CRC16: begin
        r = {16'h0, r[15:0] ^ {8'h0, b}};
        repeat (8) r = r[0] ? ((r >> 1) ^ 32'h0000_A001) : (r >> 1);
        chk_update = r;
      end
      cfr_pkg::MODE_CRC32: begin
        r = r ^ {24'h0, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
        chk_update = r;
      end
      default: chk_update = 32'h0;
    endcase
  endfunction

  // The final value as it is sent on the wire, masked to the check width.
  function automatic logic [31:0] chk_wire(input logic [1:0] m, input logic [31:0] c);
    case (m)
      cfr_pkg::MODE_XOR8:  chk_wire = {24'h0, ~c[7:0]};
      cfr_pkg::MODE_CRC16: chk_wire = {16'h0, c[15:0]};
      cfr_pkg::MODE_CRC32: chk_wire = ~c;
      default:             chk_wire = 32'h0;
    endcase
  endfunction

  function automatic logic [31:0] chk_mask(input logic [1:0] m);
    case (m)
      cfr_pkg::MODE_NONE:  chk_mask = 32'h0;
      cfr_pkg::MODE_XOR8:  chk_mask = 32'hFF;
      cfr_pkg::MODE_CRC16: chk_mask = 32'hFFFF;
      default:             chk_mask = 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic open_frame();
    run_chk = chk_seed(mode_m);
    if (start_en_m) run_chk = chk_update(mode_m, run_chk, start_val_m);
    drop_frame = 1'b0;
    ph = P_IDENT;
    cnt = '0;
  endtask

  task automatic queue_frame();
    int n;
    cfr_pkg::out_item_t r;
    r.frame_ident = f_ident;
    r.frame_kind = f_kind;
    if (f_len == 0) begin
      r.frame_length = '0;
      r.payload_byte = '0;
      r.last = 1'b1;
      pending_frames.push_back(r);
    end else begin
      n = (f_len > 32) ? 32 : int'(f_len);
      for (int k = 0; k < n; k++) begin
        r.frame_length = f_len[5:0];
        r.payload_byte = pay_mem[k];
        r.last = (k == n - 1);
        pending_frames.push_back(r);
      end
    end
  endtask

  task automatic start_payload();
    ph = P_DATA;
    cnt = '0;
    run_chk = chk_seed(mode_m);
    drop_frame = (f_len > 32);
  endtask

  // Advances the predicted parser by one accepted item.
  task automatic predict_item(input cfr_pkg::in_item_t it);
    logic [7:0] c;
    c = it.byte_in;
    if (it.command) begin
      if (ticks < idle_lim_m) ticks++;
      return;
    end
    if (ticks >= idle_lim_m) ph = P_START;
    ticks = '0;
    if (!start_en_m && ph == P_START) open_frame();
    case (ph)
      P_START: begin
        if (c == start_val_m) open_frame();
      end
      P_IDENT: begin
        run_chk = chk_update(mode_m, run_chk, c);
        f_ident = c;
        ph = P_LEN;
        cnt = '0;
      end
      P_LEN: begin
        run_chk = chk_update(mode_m, run_chk, c);
        f_len = {f_len[7:0], c};
        cnt++;
        if (cnt >= 2) begin
          ph = P_KIND;
          cnt = '0;
        end
      end
      P_KIND: begin
        run_chk = chk_update(mode_m, run_chk, c);
        f_kind = c;
        if (chk_len(mode_m) != 0) begin
          ph = P_HCHECK;
          cnt = '0;
          rx_chk = '0;
        end else if (f_len == 0) begin
          ph = P_START;
          queue_frame();
        end else begin
          start_payload();
        end
      end
      P_HCHECK: begin
        rx_chk = {rx_chk[23:0], c};
        cnt++;
        if (cnt >= chk_len(mode_m)) begin
          if ((chk_wire(mode_m, run_chk) & chk_mask(mode_m)) !=
              (rx_chk & chk_mask(mode_m))) begin
            ph = P_START;
          end else if (f_len == 0) begin
            ph = P_START;
            queue_frame();
          end else begin
            start_payload();
          end
        end
      end
      P_DATA: begin
        if (!drop_frame) begin
          run_chk = chk_update(mode_m, run_chk, c);
          if (cnt < 32) pay_mem[cnt[4:0]] = c;
        end
        cnt++;
        if (cnt >= f_len) begin
          if (chk_len(mode_m) != 0) begin
            ph = P_DCHECK;
            cnt = '0;
            rx_chk = '0;
          end else begin
            ph = P_START;
            if (!drop_frame) queue_frame();
          end
        end
      end
      P_DCHECK: begin
        rx_chk = {rx_chk[23:0], c};
        cnt++;
        if (cnt >= chk_len(mode_m)) begin
          ph = P_START;
          if (!drop_frame && (chk_wire(mode_m, run_chk) & chk_mask(mode_m)) ==
              (rx_chk & chk_mask(mode_m)))
            queue_frame();
        end
      end
      default: ph = P_START;
    endcase
  endtask

  // Sends one item; it is predicted once the block has taken it. The valid
  // stays up after the item is taken so that the next item follows at once;
  // callers that go quiet drop it themselves.
  task automatic push_item(input logic cmd, input logic [7:0] b);
    cfr_pkg::in_item_t it;
    it.command = cmd;
    it.byte_in = b;
    if (sender_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it);
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_item(1'b0, b);
  endtask

  // Sends a complete frame in the current configuration; a corrupt header or
  // payload has one bit of its check flipped.
  task automatic push_frame(input logic [7:0] id, input logic [15:0] len,
                            input logic [7:0] kind, input bit corrupt_hdr,
                            input bit corrupt_pay);
    logic [31:0] c;
    logic [31:0] w;
    logic [7:0]  b;
    int          nb;
    nb = int'(chk_len(mode_m));
    c = chk_seed(mode_m);
    if (start_en_m) begin
      push_byte(start_val_m);
      c = chk_update(mode_m, c, start_val_m);
    end
    c = chk_update(mode_m, c, id);
    c = chk_update(mode_m, c, len[15:8]);
    c = chk_update(mode_m, c, len[7:0]);
    c = chk_update(mode_m, c, kind);
    push_byte(id);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
    push_byte(kind);
    w = chk_wire(mode_m, c);
    if (corrupt_hdr) w ^= 32'h1;
    for (int i = nb - 1; i >= 0; i--) push_byte(w[8*i +: 8]);
    if (len == 0) return;
    c = chk_seed(mode_m);
    for (int i = 0; i < int'(len); i++) begin
      b = 8'($urandom_range(0, 255));
      c = chk_update(mode_m, c, b);
      push_byte(b);
    end
    w = chk_wire(mode_m, c);
    if (corrupt_pay) w ^= 32'h80;
    for (int i = nb - 1; i >= 0; i--) push_byte(w[8*i +: 8]);
  endtask

  // Writes one register while the block is idle: the write waits until every
  // expected result has been taken, and a quiet stretch precedes it.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      cfr_pkg::REG_CHECK_MODE: mode_m = val[1:0];
      cfr_pkg::REG_USE_START:  start_en_m = val[0];
      cfr_pkg::REG_START_VAL:  start_val_m = val[7:0];
      default:                 idle_lim_m = val[15:0];
    endcase
  endtask

  task automatic setup(input logic [1:0] m, input logic s, input logic [7:0] v,
                       input logic [15:0] lim);
    write_reg(cfr_pkg::REG_CHECK_MODE, {30'h0, m});
    write_reg(cfr_pkg::REG_USE_START, {31'h0, s});
    write_reg(cfr_pkg::REG_START_VAL, {24'h0, v});
    write_reg(cfr_pkg::REG_IDLE_LIMIT, {16'h0, lim});
  endtask

  // Directed frames at the field extremes, in CRC-16 mode and with no check.
  task automatic test_directed();
    push_frame(8'h00, 16'd0, 8'h00, 1'b0, 1'b0);
    push_frame(8'hFF, 16'd1, 8'hFF, 1'b0, 1'b0);
    push_frame(8'hA5, 16'd32, 8'h5A, 1'b0, 1'b0);
    setup(cfr_pkg::MODE_NONE, 1'b0, 8'hFF, 16'hFFFF);
    push_frame(8'h3C, 16'd2, 8'hC3, 1'b0, 1'b0);
    push_frame(8'h11, 16'd0, 8'h22, 1'b0, 1'b0);
  endtask

  // Bad checks, over-long payloads and idle timeouts drop the frame.
  task automatic test_errors();
    setup(cfr_pkg::MODE_XOR8, 1'b1, 8'h7E, 16'd3);
    push_frame(8'h01, 16'd3, 8'h02, 1'b1, 1'b0);
    push_frame(8'h03, 16'd3, 8'h04, 1'b0, 1'b1);
    push_frame(8'h05, 16'd33, 8'h06, 1'b0, 1'b0);
    push_byte(8'h7E);
    push_byte(8'h09);
    repeat (4) push_item(1'b1, 8'($urandom_range(0, 255)));
    push_frame(8'h0A, 16'd1, 8'h0B, 1'b0, 1'b0);
    write_reg(cfr_pkg::REG_IDLE_LIMIT, 32'd0);
    push_frame(8'h0C, 16'd1, 8'h0D, 1'b0, 1'b0);
    write_reg(cfr_pkg::REG_IDLE_LIMIT, 32'd10);
  endtask

  // Frames with random content, some with a bad check or an over-long payload, mixed with noise and ticks.
  task automatic test_random(input int items);
    int sent;
    logic [15:0] len;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 4) == 0) begin
        push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        sent++;
      end else begin
        len = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 40))
                                           : 16'($urandom_range(0, 6));
        push_frame(8'($urandom_range(0, 255)), len, 8'($urandom_range(0, 255)),
                   $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
        sent += int'(len) + 8;
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering items.
  task automatic test_backpressure();
    long_hold_req = 1'b1;
    push_frame(8'h44, 16'd8, 8'h55, 1'b0, 1'b0);
    push_frame(8'h66, 16'd4, 8'h77, 1'b0, 1'b0);
    // Sender pauses until all results have drained.
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  // Each result is taken at an edge where out_valid is high and stall low.
  always @(posedge clk) begin
    cfr_pkg::out_item_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        errors++;
      end else begin
        exp_r = pending_frames.pop_front();
        if (out_item.frame_ident !== exp_r.frame_ident)
          $display("%0t: ident expected %h actual %h", $time, exp_r.frame_ident,
                   out_item.frame_ident);
        if (out_item.frame_kind !== exp_r.frame_kind)
          $display("%0t: kind expected %h actual %h", $time, exp_r.frame_kind,
                   out_item.frame_kind);
        if (out_item.frame_length !== exp_r.frame_length)
          $display("%0t: length expected %0d actual %0d", $time, exp_r.frame_length,
                   out_item.frame_length);
        if (out_item.payload_byte !== exp_r.payload_byte)
          $display("%0t: payload expected %h actual %h", $time, exp_r.payload_byte,
                   out_item.payload_byte);
        if (out_item.last !== exp_r.last)
          $display("%0t: last expected %b actual %b", $time, exp_r.last, out_item.last);
        if (out_item !== exp_r) errors++;
      end
    end
  end

  // Receiver stall: a long hold when asked, otherwise random bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cycles <= 0;
      long_hold_done <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      out_stall <= 1'b1;
      hold_cycles <= 200;
      long_hold_done <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (recv_idle_en && !out_stall && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      hold_cycles <= int'($urandom_range(0, 15));
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    long_hold_req = 1'b0;
    sender_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    mode_m = cfr_pkg::MODE_CRC16;
    start_en_m = 1'b1;
    start_val_m = 8'h01;
    idle_lim_m = 16'd10;
    ph = P_START;
    cnt = '0;
    f_ident = '0;
    f_len = '0;
    f_kind = '0;
    run_chk = '0;
    rx_chk = '0;
    drop_frame = 1'b0;
    ticks = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_errors();
    setup(cfr_pkg::MODE_CRC32, 1'b1, 8'h00, 16'd10);
    test_backpressure();
    test_random(15);
    setup(cfr_pkg::MODE_CRC16, 1'b1, 8'hAA, 16'd40);
    test_random(15);
    setup(cfr_pkg::MODE_XOR8, 1'b0, 8'h01, 16'd5);
    test_random(15);
    setup(cfr_pkg::MODE_NONE, 1'b1, 8'h55, 16'd65535);
    sender_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    test_random(15);
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_frames.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/cfr_pkg.sv
design/cfr_parser.sv
design/cfr_readout.sv
design/checked_frame_receiver.sv
verif/checked_frame_receiver_tb.sv
